### rtl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and command codes of the multichannel sample ring.
// ----------------------------------------------------------------------------
`default_nettype none

package msr_pkg;

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_SNAP = 2'd1;
	localparam logic [1:0] CMD_STAT = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic push;
		logic load;
		logic rd;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_push;
		logic is_emit;
		logic rem_one;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

### rtl/msr_ctrl.sv
// ----------------------------------------------------------------------------
// msr_ctrl
// Sequencer: takes one item at a time and steps the ring reads.
// ----------------------------------------------------------------------------
`default_nettype none

module msr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire msr_pkg::dp_sts_t   sts,
	output msr_pkg::ctrl_cmd_t      ctl
);
	import msr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctl      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.push = sts.is_push;
					ctl.load = sts.is_emit;
					if (sts.is_emit) begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (sts.out_free) begin
					ctl.rd = 1'b1;
					if (sts.rem_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/msr_datapath.sv
// ----------------------------------------------------------------------------
// msr_datapath
// Per-channel counters, sample memory, read cursor and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msr_datapath #(
	parameter int CHANNELS = 8,
	parameter int DEPTH    = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire msr_pkg::ctrl_cmd_t   ctl,
	output msr_pkg::dp_sts_t          sts,
	input  wire logic [1:0]           cmd,
	input  wire logic [3:0]           channel,
	input  wire logic signed [63:0]   timestamp,
	input  wire logic [63:0]          sample_value,
	input  wire logic [7:0]           count,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [63:0]        timestamp_out,
	output logic [63:0]               value_out,
	output logic                      has_sample,
	output logic [31:0]               pushed_total,
	output logic                      last
);
	import msr_pkg::*;

	localparam int RING_W = $clog2(DEPTH);
	localparam int RING   = 1 << RING_W;
	localparam int FILL_W = RING_W + 1;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int NCH    = 1 << CH_W;
	localparam int ADDR_W = CH_W + RING_W;
	localparam int MEM_N  = 1 << ADDR_W;

	logic [31:0]        total_q [NCH];
	logic [FILL_W-1:0]  fill_q  [NCH];

	logic [63:0]        time_mem  [MEM_N];
	logic [63:0]        value_mem [MEM_N];

	logic [CH_W-1:0]    ch_idx;
	logic               ch_ok;
	logic [31:0]        cur_total;
	logic [FILL_W-1:0]  cur_fill;
	logic [FILL_W-1:0]  take;
	logic               is_snap;
	logic               is_stat;
	logic [ADDR_W-1:0]  wr_addr;

	logic [CH_W-1:0]    ch_q;
	logic [RING_W-1:0]  slot_q;
	logic [FILL_W-1:0]  rem_q;
	logic               has_q;
	logic [31:0]        tot_q;

	logic [63:0]        rd_time_q;
	logic [63:0]        rd_value_q;
	logic               out_valid_q;
	logic               last_q;
	logic               has_out_q;
	logic [31:0]        tot_out_q;

	assign ch_idx    = channel[CH_W-1:0];
	assign ch_ok     = ({1'b0, channel} < 5'(CHANNELS));
	assign cur_total = total_q[ch_idx];
	assign cur_fill  = fill_q[ch_idx];
	assign take      = (count < 8'(cur_fill)) ? count[FILL_W-1:0] : cur_fill;
	assign is_snap   = ch_ok && (cmd == CMD_SNAP) && (count != 8'd0)
		&& (cur_fill != '0);
	assign is_stat   = ch_ok && (cmd == CMD_STAT);
	assign wr_addr   = {ch_idx, cur_total[RING_W-1:0]};

	assign sts.is_push  = ch_ok && (cmd == CMD_PUSH);
	assign sts.is_emit  = is_snap || is_stat;
	assign sts.rem_one  = (rem_q == FILL_W'(1));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				total_q[i] <= '0;
				fill_q[i]  <= '0;
			end
		end else if (ctl.push) begin
			total_q[ch_idx] <= cur_total + 32'd1;
			if (cur_fill != FILL_W'(RING)) begin
				fill_q[ch_idx] <= cur_fill + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			time_mem[wr_addr]  <= timestamp;
			value_mem[wr_addr] <= sample_value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_time_q  <= time_mem[{ch_q, slot_q}];
			rd_value_q <= value_mem[{ch_q, slot_q}];
		end
	end

	// read cursor
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ch_q  <= ch_idx;
			tot_q <= cur_total;
			if (is_snap) begin
				slot_q <= cur_total[RING_W-1:0] - take[RING_W-1:0];
				rem_q  <= take;
				has_q  <= 1'b1;
			end else begin
				slot_q <= cur_total[RING_W-1:0] - RING_W'(1);
				rem_q  <= FILL_W'(1);
				has_q  <= (cur_fill != '0);
			end
		end else if (ctl.rd) begin
			slot_q <= slot_q + RING_W'(1);
			rem_q  <= rem_q - FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.rd) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			last_q    <= (rem_q == FILL_W'(1));
			has_out_q <= has_q;
			tot_out_q <= tot_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign timestamp_out = has_out_q ? signed'(rd_time_q) : '0;
	assign value_out     = has_out_q ? rd_value_q : '0;
	assign has_sample    = has_out_q;
	assign pushed_total  = tot_out_q;
	assign last          = last_q;

endmodule

`default_nettype wire

### rtl/multichannel_sample_ring.sv
// ----------------------------------------------------------------------------
// multichannel_sample_ring
// Per-channel rings of timestamped samples with push, snapshot and status.
// ----------------------------------------------------------------------------
// One item is taken at a time. A push or an ignored item (channel out of range,
// unused command, or a snapshot that finds nothing) is taken without leaving
// the idle state. A status query keeps the block busy for one read and a
// snapshot of n samples for n reads, one sample per cycle from the single
// read port of the sample memory while the output is not stalled. The last
// result waits in the output register while the next item is taken. No
// clearing pass is needed after reset.
`default_nettype none

module multichannel_sample_ring #(
	parameter int CHANNELS = 8,
	parameter int DEPTH    = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          cmd,
	input  wire logic [3:0]          channel,
	input  wire logic signed [63:0]  timestamp,
	input  wire logic [63:0]         sample_value,
	input  wire logic [7:0]          count,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [63:0]       timestamp_out,
	output logic [63:0]              value_out,
	output logic                     has_sample,
	output logic [31:0]              pushed_total,
	output logic                     last
);
	import msr_pkg::*;

	ctrl_cmd_t ctl;
	dp_sts_t   sts;

	msr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	msr_datapath #(
		.CHANNELS (CHANNELS),
		.DEPTH    (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.channel       (channel),
		.timestamp     (timestamp),
		.sample_value  (sample_value),
		.count         (count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.timestamp_out (timestamp_out),
		.value_out     (value_out),
		.has_sample    (has_sample),
		.pushed_total  (pushed_total),
		.last          (last)
	);

endmodule

`default_nettype wire

### rtl/msr_checker.sv
// ----------------------------------------------------------------------------
// msr_checker
// Port-level checks of the sample ring, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module msr_checker #(
	parameter int CHANNELS = 8
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic [1:0]          cmd,
	input wire logic [3:0]          channel,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic signed [63:0]  timestamp_out,
	input wire logic [63:0]         value_out,
	input wire logic                has_sample,
	input wire logic [31:0]         pushed_total,
	input wire logic                last
);
	import msr_pkg::*;

	logic in_acc;
	logic ch_ok;

	assign in_acc = in_valid && in_ready;
	assign ch_ok  = ({1'b0, channel} < 5'(CHANNELS));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(timestamp_out)
			&& $stable(value_out) && $stable(pushed_total) && $stable(last))
		else $error("result beat changed while stalled");

	a_push_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (cmd == CMD_PUSH) && !out_valid |=> !out_valid)
		else $error("push produced a result beat");

	a_status_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (cmd == CMD_STAT) && ch_ok && (!out_valid || out_ready)
			|=> ##1 out_valid && last)
		else $error("status query did not give a single final beat");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_sample |-> (timestamp_out == '0) && (value_out == '0))
		else $error("empty status beat carries sample data");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("new item taken mid snapshot");

endmodule

bind multichannel_sample_ring msr_checker #(.CHANNELS(CHANNELS)) u_msr_checker (.*);

`default_nettype wire

### bench/tb_multichannel_sample_ring.sv
// ----------------------------------------------------------------------------
// tb_multichannel_sample_ring
// Self-checking bench for the multichannel sample ring. A shadow copy of
// every channel's ring, write total and fill level predicts the results of
// each accepted command beat. The results are compared field by field, in
// order, with the beats that leave the block. Commands arrive in bursts with
// random gaps. The result side stalls on a pattern of its own.
// ----------------------------------------------------------------------------

module tb_multichannel_sample_ring;
	import msr_pkg::*;

	localparam int CHANNELS = 8;
	localparam int DEPTH    = 64;
	localparam int RING     = (DEPTH <= 2) ? 2 : (1 << $clog2(DEPTH));
	localparam int ITEMS    = 180;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct {
		logic [63:0] stamp;
		logic [63:0] payload;
		logic        has;
		logic [31:0] total;
		logic        is_last;
	} ring_result_t;

	class ring_shadow;
		logic [63:0]  stamp_mem [CHANNELS][RING];
		logic [63:0]  payload_mem [CHANNELS][RING];
		bit [31:0]    pushes [CHANNELS];
		int unsigned  level [CHANNELS];
		ring_result_t awaited_samples[$];
		int           errors;

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		function int pending();
			return awaited_samples.size();
		endfunction

		function void note_command(logic [1:0] c, logic [3:0] chan, logic [63:0] stamp,
				logic [63:0] payload, logic [7:0] n);
			int unsigned  ch;
			int unsigned  slot;
			int unsigned  take;
			bit [31:0]    first;
			ring_result_t r;
			ch = 32'(chan);
			if (ch >= CHANNELS)
				return;
			case (c)
				CMD_PUSH: begin
					slot = pushes[ch] % RING;
					stamp_mem[ch][slot]   = stamp;
					payload_mem[ch][slot] = payload;
					pushes[ch]++;
					if (level[ch] < RING)
						level[ch]++;
				end
				CMD_SNAP: begin
					take = 32'(n);
					if (take == 0 || level[ch] == 0)
						return;
					if (take > level[ch])
						take = level[ch];
					if (take > RING)
						take = RING;
					first = pushes[ch] - take;
					for (int i = 0; i < take; i++) begin
						slot = (first + i) % RING;
						r.stamp   = stamp_mem[ch][slot];
						r.payload = payload_mem[ch][slot];
						r.has     = 1'b1;
						r.total   = pushes[ch];
						r.is_last = (i == take - 1);
						awaited_samples.insert(awaited_samples.size(), r);
					end
				end
				CMD_STAT: begin
					r.total   = pushes[ch];
					r.is_last = 1'b1;
					if (level[ch] == 0) begin
						r.stamp   = '0;
						r.payload = '0;
						r.has     = 1'b0;
					end else begin
						slot = (pushes[ch] - 1) % RING;
						r.stamp   = stamp_mem[ch][slot];
						r.payload = payload_mem[ch][slot];
						r.has     = 1'b1;
					end
					awaited_samples.insert(awaited_samples.size(), r);
				end
				default: ;
			endcase
		endfunction

		task compare_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("%s got %h expected %h", name, got, want));
		endtask

		task check_sample(logic [63:0] stamp, logic [63:0] payload, logic has,
				logic [31:0] total, logic is_last);
			ring_result_t w;
			if (awaited_samples.size() == 0) begin
				report($sformatf("unexpected result beat ts %h value %h", stamp, payload));
				return;
			end
			w = awaited_samples.pop_front();
			compare_field("timestamp_out", stamp, w.stamp);
			compare_field("value_out", payload, w.payload);
			compare_field("has_sample", 64'(has), 64'(w.has));
			compare_field("pushed_total", 64'(total), 64'(w.total));
			compare_field("last", 64'(is_last), 64'(w.is_last));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         cmd = CMD_PUSH;
	logic [3:0]         channel = '0;
	logic signed [63:0] timestamp = '0;
	logic [63:0]        sample_value = '0;
	logic [7:0]         count = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [63:0] timestamp_out;
	logic [63:0]        value_out;
	logic               has_sample;
	logic [31:0]        pushed_total;
	logic               last;

	ring_shadow shadow;
	int         burst_left = 0;
	int         rx_mode = 0;
	int         rx_left = 0;

	multichannel_sample_ring #(
		.CHANNELS(CHANNELS),
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.channel(channel),
		.timestamp(timestamp),
		.sample_value(sample_value),
		.count(count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.timestamp_out(timestamp_out),
		.value_out(value_out),
		.has_sample(has_sample),
		.pushed_total(pushed_total),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			shadow.note_command(cmd, channel, timestamp, sample_value, count);
		if (arst_n && out_valid && out_ready)
			shadow.check_sample(timestamp_out, value_out, has_sample, pushed_total, last);
	end

	// result side: free-flowing, choppy or mostly stalled, in stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 8'd0;
			1: return 8'($urandom_range(RING + 1, 255));
			2: return 8'(RING);
			default: return 8'($urandom_range(1, 40));
		endcase
	endfunction

	// one beat, then a random gap once the current burst runs out
	task automatic feed(input logic [1:0] c, input logic [3:0] ch, input logic [63:0] stamp,
			input logic [63:0] payload, input logic [7:0] n);
		in_valid     <= 1'b1;
		cmd          <= c;
		channel      <= ch;
		timestamp    <= stamp;
		sample_value <= payload;
		count        <= n;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 40);
		end else begin
			burst_left--;
		end
	endtask

	initial begin
		int          counted;
		int          kind;
		int          len;
		logic [3:0]  ch;
		logic [1:0]  c;
		shadow = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		feed(CMD_STAT, 4'd0, '0, '0, 8'd0);
		feed(CMD_SNAP, 4'd0, '0, '0, 8'd5);
		feed(CMD_PUSH, 4'd0, 64'h8000_0000_0000_0000, 64'h0, 8'd0);
		feed(CMD_PUSH, 4'd0, 64'h7fff_ffff_ffff_ffff, '1, 8'd255);
		feed(CMD_PUSH, 4'd7, '1, 64'h5555_5555_5555_5555, 8'd0);
		feed(CMD_PUSH, 4'd7, '0, 64'haaaa_aaaa_aaaa_aaaa, 8'd0);
		feed(CMD_SNAP, 4'd0, '0, '0, 8'd0);
		feed(CMD_SNAP, 4'd0, '0, '0, 8'd1);
		feed(CMD_SNAP, 4'd0, '1, '1, 8'd255);
		feed(CMD_STAT, 4'd0, '0, '0, 8'd0);
		feed(CMD_STAT, 4'd7, '0, '0, 8'd0);
		feed(CMD_PUSH, 4'd8, '1, '1, 8'd0);
		feed(CMD_SNAP, 4'd15, '0, '0, 8'd255);
		feed(CMD_STAT, 4'd15, '0, '0, 8'd0);
		feed(CMD_SPARE, 4'd0, '1, '1, 8'd255);
		feed(CMD_SNAP, 4'd7, '0, '0, 8'd2);
		feed(CMD_STAT, 4'd1, '0, '0, 8'd0);
		feed(CMD_SNAP, 4'd3, '0, '0, 8'd255);

		counted = 0;
		while (counted < ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				// fill run on one channel, channel 0 favoured so its ring wraps
				ch = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(0, CHANNELS - 1));
				len = $urandom_range(1, 30);
				repeat (len) feed(CMD_PUSH, ch, rand64(), rand64(), 8'($urandom));
				if ($urandom_range(0, 1))
					feed(CMD_SNAP, ch, rand64(), rand64(), pick_count());
				else
					feed(CMD_STAT, ch, rand64(), rand64(), 8'($urandom));
				counted += len + 1;
			end else if (kind < 88) begin
				c = $urandom_range(0, 1) ? CMD_SNAP : CMD_STAT;
				feed(c, 4'($urandom_range(0, CHANNELS - 1)), rand64(), rand64(), pick_count());
				counted++;
			end else if (kind < 94) begin
				feed(CMD_SPARE, 4'($urandom), rand64(), rand64(), 8'($urandom));
			end else begin
				c = 2'($urandom_range(0, 2));
				feed(c, 4'($urandom_range(CHANNELS, 15)), rand64(), rand64(), 8'($urandom));
			end
		end

		in_valid <= 1'b0;
		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (RING + 8) @(posedge clk);
		if (shadow.errors == 0)
			$display("multichannel_sample_ring test passed");
		else
			$display("multichannel_sample_ring test failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("multichannel_sample_ring test failed");
		$finish;
	end

endmodule
